// ===== hw/rtl/cti_pkg.sv =====
`timescale 1ns / 1ps
package cti_pkg;

    localparam int KIND_W    = 2;
    localparam int TAU_W     = 32;
    localparam int PER_W     = 31;
    localparam int STEP_W    = 32;
    localparam int VAL_W     = 32;
    localparam int ORB_FW    = 4;
    localparam int IV_W      = 6;
    localparam int SLOT_W    = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 32;
    localparam int FRAC_W    = 16;
    localparam int TFRAC_W   = 24;
    localparam int PROD_W    = PER_W + STEP_W;
    localparam int IPART_W   = PROD_W - TFRAC_W - FRAC_W;
    localparam int F_W       = FRAC_W + 1;
    localparam int ACC_W     = 36;
    localparam int MUL_W     = ACC_W + F_W + 1;
    localparam int NCOEF     = 4;

    localparam logic [PER_W-1:0]  PERIOD_RST = 31'd16777216;
    localparam logic [STEP_W-1:0] STEPS_RST  = 32'd4128768;
    localparam logic [F_W-1:0]    FRAC_ONE   = 17'h10000;

    localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_STEPS  = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_EVAL = 2'd0,
        KIND_COEF = 2'd1,
        KIND_ZERO = 2'd2
    } cti_kind_t;

    typedef struct packed {
        logic valid;
        logic neg;
        logic oor;
        logic zero;
        logic bad;
    } cti_ctl_t;

endpackage

// ===== hw/rtl/cti_map.sv =====
`timescale 1ns / 1ps
module cti_map #(
    parameter int TIME_POINTS = 64,
    parameter int ORBITALS    = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              eval_go,
    input  logic signed [cti_pkg::TAU_W-1:0]  tau,
    input  logic [cti_pkg::ORB_FW-1:0]        orbital,
    input  logic [cti_pkg::PER_W-1:0]         period,
    input  logic [cti_pkg::STEP_W-1:0]        steps,
    output logic [$clog2(TIME_POINTS*ORBITALS)-1:0] rd_row,
    output logic [((ORBITALS > 1) ? $clog2(ORBITALS) : 1)-1:0] rd_orb,
    output cti_pkg::cti_ctl_t                 ctl,
    output logic [cti_pkg::F_W-1:0]           frac
);
    import cti_pkg::*;

    localparam int ROWS  = TIME_POINTS * ORBITALS;
    localparam int ROW_W = $clog2(ROWS);
    localparam int ZA_W  = (ORBITALS > 1) ? $clog2(ORBITALS) : 1;
    localparam int IDX_W = $clog2(TIME_POINTS);

    // stage 1: fold time into the period
    logic signed [TAU_W:0] t_sum;
    logic signed [TAU_W:0] per_s;
    logic [PER_W-1:0]      t_next;
    cti_ctl_t              ctl1_next;
    cti_ctl_t              ctl1_reg;
    logic [PER_W-1:0]      t1_reg;
    logic [ORB_FW-1:0]     orb1_reg;

    // stage 2: scale
    cti_ctl_t              ctl2_reg;
    logic [PROD_W-1:0]     prod2_reg;
    logic [ORB_FW-1:0]     orb2_reg;

    // stage 3: interval and fraction
    logic [IPART_W-1:0]    ipart;
    logic                  last;
    logic [IDX_W-1:0]      idx_sel;
    logic [F_W-1:0]        frac_next;
    cti_ctl_t              ctl3_reg;
    logic [F_W-1:0]        frac3_reg;

    always_comb
    begin
        per_s     = $signed({2'b00, period});
        ctl1_next = '0;
        ctl1_next.valid = eval_go;
        ctl1_next.neg   = tau[TAU_W-1];
        ctl1_next.zero  = (tau == '0);
        ctl1_next.bad   = !(32'(orbital) < 32'(ORBITALS));
        t_sum = (TAU_W+1)'(tau) + (tau[TAU_W-1] ? per_s : '0);
        if (t_sum < 0)
        begin
            t_next        = '0;
            ctl1_next.oor = 1'b1;
        end
        else if (t_sum > per_s)
        begin
            t_next        = period;
            ctl1_next.oor = 1'b1;
        end
        else
        begin
            t_next = t_sum[PER_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
        end
        else
        begin
            ctl1_reg <= ctl1_next;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        t1_reg    <= t_next;
        orb1_reg  <= orbital;
        prod2_reg <= PROD_W'(t1_reg) * PROD_W'(steps);
        orb2_reg  <= orb1_reg;
        frac3_reg <= frac_next;
    end

    always_comb
    begin
        ipart = prod2_reg[PROD_W-1 -: IPART_W];
        last  = (ipart >= IPART_W'(TIME_POINTS - 1));
        if (last)
        begin
            idx_sel   = IDX_W'(TIME_POINTS - 2);
            frac_next = FRAC_ONE;
        end
        else
        begin
            idx_sel   = ipart[IDX_W-1:0];
            frac_next = {1'b0, prod2_reg[TFRAC_W +: FRAC_W]};
        end
        if (ctl2_reg.bad)
            rd_row = '0;
        else
            rd_row = ROW_W'(orb2_reg) * ROW_W'(TIME_POINTS) + ROW_W'(idx_sel);
    end

    assign rd_orb = ZA_W'(orb2_reg);
    assign ctl    = ctl3_reg;
    assign frac   = frac3_reg;

endmodule

// ===== hw/rtl/cti_mem.sv =====
`timescale 1ns / 1ps
module cti_mem #(
    parameter int TIME_POINTS = 64,
    parameter int ORBITALS    = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    input  logic [cti_pkg::KIND_W-1:0]              kind,
    input  logic [cti_pkg::ORB_FW-1:0]              orbital,
    input  logic [cti_pkg::IV_W-1:0]                interval,
    input  logic [cti_pkg::SLOT_W-1:0]              slot,
    input  logic signed [cti_pkg::VAL_W-1:0]        value,
    input  logic [$clog2(TIME_POINTS*ORBITALS)-1:0] rd_row,
    input  logic [((ORBITALS > 1) ? $clog2(ORBITALS) : 1)-1:0] rd_orb,
    output logic [cti_pkg::NCOEF-1:0][cti_pkg::VAL_W-1:0] coef,
    output logic [cti_pkg::VAL_W-1:0]               zt
);
    import cti_pkg::*;

    localparam int ROWS  = TIME_POINTS * ORBITALS;
    localparam int ROW_W = $clog2(ROWS);
    localparam int ZA_W  = (ORBITALS > 1) ? $clog2(ORBITALS) : 1;

    logic              orb_ok;
    logic              coef_we;
    logic              zero_we;
    logic [ROW_W-1:0]  wr_row;
    logic [VAL_W-1:0]  zero_mem [ORBITALS];
    logic [VAL_W-1:0]  zt_rd_reg;

    logic              coef_we1_reg;
    logic              coef_we2_reg;
    logic              zero_we1_reg;
    logic              zero_we2_reg;
    logic [ROW_W-1:0]  wr_row1_reg;
    logic [ROW_W-1:0]  wr_row2_reg;
    logic [SLOT_W-1:0] slot1_reg;
    logic [SLOT_W-1:0] slot2_reg;
    logic [VAL_W-1:0]  wr_val1_reg;
    logic [VAL_W-1:0]  wr_val2_reg;
    logic [ZA_W-1:0]   zt_addr1_reg;
    logic [ZA_W-1:0]   zt_addr2_reg;

    assign orb_ok  = 32'(orbital) < 32'(ORBITALS);
    assign coef_we = start && (kind == KIND_COEF) && orb_ok
                     && (32'(interval) < 32'(TIME_POINTS));
    assign zero_we = start && (kind == KIND_ZERO) && orb_ok;
    assign wr_row  = ROW_W'(orbital) * ROW_W'(TIME_POINTS) + ROW_W'(interval);

    // writes pass through the we1 and we2 registers so a read in flight sees only older words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_we1_reg <= 1'b0;
            coef_we2_reg <= 1'b0;
            zero_we1_reg <= 1'b0;
            zero_we2_reg <= 1'b0;
        end
        else
        begin
            coef_we1_reg <= coef_we;
            coef_we2_reg <= coef_we1_reg;
            zero_we1_reg <= zero_we;
            zero_we2_reg <= zero_we1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        wr_row1_reg  <= wr_row;
        wr_row2_reg  <= wr_row1_reg;
        slot1_reg    <= slot;
        slot2_reg    <= slot1_reg;
        wr_val1_reg  <= value;
        wr_val2_reg  <= wr_val1_reg;
        zt_addr1_reg <= ZA_W'(orbital);
        zt_addr2_reg <= zt_addr1_reg;
    end

    // one bank per coefficient order so all coefficients of a row read out together
    for (genvar b = 0; b < NCOEF; b++)
    begin : g_bank
        logic [VAL_W-1:0] bank_mem [ROWS];
        logic [VAL_W-1:0] bank_rd_reg;

        always_ff @(posedge clk)
        begin
            if (coef_we2_reg && (slot2_reg == SLOT_W'(b)))
                bank_mem[wr_row2_reg] <= wr_val2_reg;
            bank_rd_reg <= bank_mem[rd_row];
        end

        assign coef[b] = bank_rd_reg;
    end

    always_ff @(posedge clk)
    begin
        if (zero_we2_reg)
            zero_mem[zt_addr2_reg] <= wr_val2_reg;
        zt_rd_reg <= zero_mem[rd_orb];
    end

    assign zt = zt_rd_reg;

endmodule

// ===== hw/rtl/cti_horner.sv =====
`timescale 1ns / 1ps
module cti_horner (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  cti_pkg::cti_ctl_t                             ctl,
    input  logic [cti_pkg::F_W-1:0]                       frac,
    input  logic [cti_pkg::NCOEF-1:0][cti_pkg::VAL_W-1:0] coef,
    input  logic [cti_pkg::VAL_W-1:0]                     zt,
    output logic                                          done,
    output logic signed [cti_pkg::VAL_W-1:0]              result,
    output logic                                          out_of_range
);
    import cti_pkg::*;

    // floor of product over 2^16 plus the next coefficient
    function automatic logic signed [ACC_W-1:0] step_add(
        input logic signed [VAL_W-1:0] c,
        input logic signed [MUL_W-1:0] p
    );
        logic signed [MUL_W-1:0] sh;
        sh = p >>> FRAC_W;
        return ACC_W'(c) + ACC_W'(sh);
    endfunction

    logic signed [F_W:0]     fs;
    logic signed [F_W:0]     fs4;
    logic signed [ACC_W-1:0] acc5;
    logic signed [ACC_W-1:0] acc6;
    logic signed [ACC_W-1:0] acc7;
    logic signed [ACC_W-1:0] fin;
    logic signed [VAL_W-1:0] sat_val;
    logic                    sat;
    logic [VAL_W-1:0]        result_next;
    logic                    oor_next;

    cti_ctl_t                ctl4_reg;
    cti_ctl_t                ctl5_reg;
    cti_ctl_t                ctl6_reg;
    logic [F_W-1:0]          frac4_reg;
    logic [F_W-1:0]          frac5_reg;
    logic signed [MUL_W-1:0] p4_reg;
    logic signed [MUL_W-1:0] p5_reg;
    logic signed [MUL_W-1:0] p6_reg;
    logic [VAL_W-1:0]        c2_4_reg;
    logic [VAL_W-1:0]        c1_4_reg;
    logic [VAL_W-1:0]        c0_4_reg;
    logic [VAL_W-1:0]        c1_5_reg;
    logic [VAL_W-1:0]        c0_5_reg;
    logic [VAL_W-1:0]        c0_6_reg;
    logic [VAL_W-1:0]        zt4_reg;
    logic [VAL_W-1:0]        zt5_reg;
    logic [VAL_W-1:0]        zt6_reg;
    logic                    done_reg;
    logic [VAL_W-1:0]        result_reg;
    logic                    oor_reg;

    assign fs   = $signed({1'b0, frac});
    assign fs4  = $signed({1'b0, frac4_reg});
    assign acc5 = step_add($signed(c2_4_reg), p4_reg);
    assign acc6 = step_add($signed(c1_5_reg), p5_reg);
    assign acc7 = step_add($signed(c0_6_reg), p6_reg);

    always_ff @(posedge clk)
    begin
        frac4_reg <= frac;
        p4_reg    <= MUL_W'($signed(coef[3])) * MUL_W'(fs);
        c2_4_reg  <= coef[2];
        c1_4_reg  <= coef[1];
        c0_4_reg  <= coef[0];
        zt4_reg   <= zt;

        frac5_reg <= frac4_reg;
        p5_reg    <= MUL_W'(acc5) * MUL_W'(fs4);
        c1_5_reg  <= c1_4_reg;
        c0_5_reg  <= c0_4_reg;
        zt5_reg   <= zt4_reg;

        p6_reg    <= MUL_W'(acc6) * MUL_W'($signed({1'b0, frac5_reg}));
        c0_6_reg  <= c0_5_reg;
        zt6_reg   <= zt5_reg;

        result_reg <= result_next;
        oor_reg    <= oor_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl4_reg <= '0;
            ctl5_reg <= '0;
            ctl6_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            ctl4_reg <= ctl;
            ctl5_reg <= ctl4_reg;
            ctl6_reg <= ctl5_reg;
            done_reg <= ctl6_reg.valid;
        end
    end

    always_comb
    begin
        fin = ctl6_reg.neg ? -acc7 : acc7;
        sat = (fin[ACC_W-1:VAL_W-1] != '0) && (fin[ACC_W-1:VAL_W-1] != '1);
        if (!sat)
            sat_val = fin[VAL_W-1:0];
        else if (fin[ACC_W-1])
            sat_val = {1'b1, {(VAL_W-1){1'b0}}};
        else
            sat_val = {1'b0, {(VAL_W-1){1'b1}}};

        if (ctl6_reg.bad)
        begin
            result_next = '0;
            oor_next    = 1'b1;
        end
        else if (ctl6_reg.zero)
        begin
            result_next = zt6_reg;
            oor_next    = 1'b0;
        end
        else
        begin
            result_next = sat_val;
            oor_next    = ctl6_reg.oor || sat;
        end
    end

    assign done         = done_reg;
    assign result       = $signed(result_reg);
    assign out_of_range = oor_reg;

endmodule

// ===== hw/rtl/cubic_table_interpolator_core.sv =====
`timescale 1ns / 1ps
// done follows an evaluate word through ctl1-ctl3 in the map, then ctl4-ctl6 and done_reg
// throughput: one word per cycle, busy stays low; the pipeline has no stall point
// rate is set by the scale multiplier and three Horner multiplier stages, one per stage
// the receiver cannot stall, so done is a one-cycle strobe
// reset: period 1.0 and steps 63.0, pipeline emptied; tables hold nothing until written
module cubic_table_interpolator_core #(
    parameter int TIME_POINTS = 64,
    parameter int ORBITALS    = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [cti_pkg::KIND_W-1:0]          kind,
    input  logic signed [cti_pkg::TAU_W-1:0]    tau,
    input  logic [cti_pkg::ORB_FW-1:0]          orbital,
    input  logic [cti_pkg::IV_W-1:0]            interval,
    input  logic [cti_pkg::SLOT_W-1:0]          slot,
    input  logic signed [cti_pkg::VAL_W-1:0]    value,
    input  logic                                cfg_we,
    input  logic [cti_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [cti_pkg::CFG_W-1:0]           cfg_data,
    output logic                                done,
    output logic signed [cti_pkg::VAL_W-1:0]    result,
    output logic                                out_of_range
);
    import cti_pkg::*;

    localparam int ROW_W = $clog2(TIME_POINTS * ORBITALS);
    localparam int ZA_W  = (ORBITALS > 1) ? $clog2(ORBITALS) : 1;

    logic [PER_W-1:0]              period_reg;
    logic [STEP_W-1:0]             steps_reg;
    logic                          accept;
    logic                          eval_go;
    logic [ROW_W-1:0]              rd_row;
    logic [ZA_W-1:0]               rd_orb;
    cti_ctl_t                      ctl3;
    logic [F_W-1:0]                frac3;
    logic [NCOEF-1:0][VAL_W-1:0]   coef3;
    logic [VAL_W-1:0]              zt3;

    assign busy    = 1'b0;
    assign accept  = start && !busy;
    assign eval_go = accept && (kind == KIND_EVAL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RST;
            steps_reg  <= STEPS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PERIOD: period_reg <= cfg_data[PER_W-1:0];
                REG_STEPS:  steps_reg  <= cfg_data[STEP_W-1:0];
            endcase
        end
    end

    cti_map #(
        .TIME_POINTS (TIME_POINTS),
        .ORBITALS    (ORBITALS)
    ) u_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .eval_go (eval_go),
        .tau     (tau),
        .orbital (orbital),
        .period  (period_reg),
        .steps   (steps_reg),
        .rd_row  (rd_row),
        .rd_orb  (rd_orb),
        .ctl     (ctl3),
        .frac    (frac3)
    );

    cti_mem #(
        .TIME_POINTS (TIME_POINTS),
        .ORBITALS    (ORBITALS)
    ) u_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .kind     (kind),
        .orbital  (orbital),
        .interval (interval),
        .slot     (slot),
        .value    (value),
        .rd_row   (rd_row),
        .rd_orb   (rd_orb),
        .coef     (coef3),
        .zt       (zt3)
    );

    cti_horner u_horner (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl3),
        .frac         (frac3),
        .coef         (coef3),
        .zt           (zt3),
        .done         (done),
        .result       (result),
        .out_of_range (out_of_range)
    );

    a_eval_done: assert property (@(posedge clk) disable iff (!rst_n)
        eval_go |-> ##7 done)
        else $error("evaluate word produced no result");

    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(eval_go, 7))
        else $error("result without an evaluate word");

    a_bad_orb: assert property (@(posedge clk) disable iff (!rst_n)
        eval_go && !(32'(orbital) < 32'(ORBITALS)) |-> ##7 (out_of_range && result == '0))
        else $error("unknown orbital not flagged");

endmodule
